// ----- hw/rtl/tfcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcd_pkg
// Shared constants and types for the time frame check and decode block.
// ----------------------------------------------------------------------------
package tfcd_pkg;

   localparam int unsigned WinLen   = 16;
   localparam int unsigned ByteW    = 8;
   localparam int unsigned SumFirst = 4;
   localparam int unsigned CheckPos = 14;
   localparam int unsigned EndPos   = 15;
   localparam int unsigned DataPos  = 7;

   localparam logic [ByteW-1:0] StartByte = 8'h68;
   localparam logic [ByteW-1:0] LenByte   = 8'h0A;
   localparam logic [ByteW-1:0] EndByte   = 8'h16;

   // position 0 holds the oldest byte
   typedef logic [WinLen-1:0][ByteW-1:0] window_type;

   typedef struct packed {
      logic       frame_ok;
      logic [9:0] millis;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hour;
      logic       summer_time;
      logic [4:0] day;
      logic [2:0] weekday;
      logic [3:0] month;
      logic [6:0] year;
   } result_type;

endpackage

// ----- hw/rtl/tfcd_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcd_window
// Sixteen-byte sliding window; shifts in one byte per input transfer.
// ----------------------------------------------------------------------------
module tfcd_window (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift_en,
   input  logic [7:0]                rx_byte,
   output tfcd_pkg::window_type      window
);
   import tfcd_pkg::*;

   window_type window_ff;
   window_type window_in;

   always_comb begin
      window_in = window_ff;
      if (shift_en) begin
         for (int i = 0; i < WinLen - 1; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[WinLen-1] = rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   assign window = window_ff;

endmodule

// ----- hw/rtl/tfcd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcd_decode
// Frame check (start bytes, checksum, end byte) and time field unpacking.
// ----------------------------------------------------------------------------
module tfcd_decode (
   input  tfcd_pkg::window_type  window,
   output tfcd_pkg::result_type  result
);
   import tfcd_pkg::*;

   logic [ByteW-1:0] sum_lo;
   logic [ByteW-1:0] sum_hi;
   logic [ByteW-1:0] sum;
   logic             start_ok;
   logic             match;
   logic [ByteW-1:0] d0, d1, d2, d3, d4, d5, d6;

   // 8-bit checksum over positions 4 to 13, split in two halves
   assign sum_lo = window[SumFirst] + window[SumFirst+1] + window[SumFirst+2]
                 + window[SumFirst+3] + window[SumFirst+4];
   assign sum_hi = window[SumFirst+5] + window[SumFirst+6] + window[SumFirst+7]
                 + window[SumFirst+8] + window[SumFirst+9];
   assign sum    = sum_lo + sum_hi;

   assign start_ok = (window[0] == StartByte) && (window[1] == LenByte)
                  && (window[2] == LenByte)   && (window[3] == StartByte);
   assign match    = start_ok && (window[CheckPos] == sum)
                  && (window[EndPos] == EndByte);

   assign d0 = window[DataPos];
   assign d1 = window[DataPos+1];
   assign d2 = window[DataPos+2];
   assign d3 = window[DataPos+3];
   assign d4 = window[DataPos+4];
   assign d5 = window[DataPos+5];
   assign d6 = window[DataPos+6];

   always_comb begin
      result = '0;
      if (match) begin
         result.frame_ok    = 1'b1;
         result.millis      = {d1[1:0], d0};
         result.seconds     = d1[7:2];
         result.minutes     = d2[5:0];
         result.hour        = d3[4:0];
         result.summer_time = d3[7];
         result.day         = d4[4:0];
         result.weekday     = d4[7:5];
         result.month       = d5[3:0];
         result.year        = d6[6:0];
      end
   end

endmodule

// ----- hw/rtl/time_frame_check_and_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_frame_check_and_decode
// Checks a sliding 16-byte window for a fixed-length time frame after every
// received byte and reports the decoded time fields, one result per byte.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_rx_byte
//   rsp       out        rsp_valid/rsp_stall  rsp_frame_ok .. rsp_year
//
// One byte per cycle sustained while rsp_stall is low. A byte enters the
// window register at its transfer edge, is checked combinationally from the
// window and lands in the result register when that register is empty or its
// result is taken. Reset is synchronous and clears the window to zero and
// drops any pending item. While a result waits under rsp_stall, one more byte
// is still taken; req_stall rises only when both stages are full, and during
// reset.
// ----------------------------------------------------------------------------
module time_frame_check_and_decode (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_frame_ok,
   output logic [9:0] rsp_millis,
   output logic [5:0] rsp_seconds,
   output logic [5:0] rsp_minutes,
   output logic [4:0] rsp_hour,
   output logic       rsp_summer_time,
   output logic [4:0] rsp_day,
   output logic [2:0] rsp_weekday,
   output logic [3:0] rsp_month,
   output logic [6:0] rsp_year
);
   import tfcd_pkg::*;

   window_type window;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       pend_ff;
   logic       pend_in;
   logic       out_free;
   logic       advance;
   logic       req_xfer;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = pend_ff && out_free;
   assign req_stall = reset || (pend_ff && !out_free);
   assign req_xfer  = req_valid && !req_stall;

   tfcd_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (req_xfer),
      .rx_byte  (req_rx_byte),
      .window   (window)
   );

   tfcd_decode u_decode (
      .window (window),
      .result (result)
   );

   always_comb begin
      pend_in      = req_xfer || (pend_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_ok    = rsp_ff.frame_ok;
   assign rsp_millis      = rsp_ff.millis;
   assign rsp_seconds     = rsp_ff.seconds;
   assign rsp_minutes     = rsp_ff.minutes;
   assign rsp_hour        = rsp_ff.hour;
   assign rsp_summer_time = rsp_ff.summer_time;
   assign rsp_day         = rsp_ff.day;
   assign rsp_weekday     = rsp_ff.weekday;
   assign rsp_month       = rsp_ff.month;
   assign rsp_year        = rsp_ff.year;

endmodule

// ----- hw/rtl/tfcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcd_checker
// Port-level assertions for time_frame_check_and_decode, bound to the top.
// ----------------------------------------------------------------------------
module tfcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_frame_ok,
   input logic [9:0] rsp_millis,
   input logic [5:0] rsp_seconds,
   input logic [5:0] rsp_minutes,
   input logic [4:0] rsp_hour,
   input logic       rsp_summer_time,
   input logic [4:0] rsp_day,
   input logic [2:0] rsp_weekday,
   input logic [3:0] rsp_month,
   input logic [6:0] rsp_year
);

   logic no_fields;

   assign no_fields = (rsp_millis == '0) && (rsp_seconds == '0) && (rsp_minutes == '0)
                   && (rsp_hour == '0) && !rsp_summer_time && (rsp_day == '0)
                   && (rsp_weekday == '0) && (rsp_month == '0) && (rsp_year == '0);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_ok)
                                    && $stable(rsp_millis) && $stable(rsp_year)))
      else $error("stalled result changed");

   // a rejected window reports all-zero time fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_ok) |-> no_fields)
      else $error("time fields nonzero without a frame");

   // a rising rsp_valid must trace back to an earlier input transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input transfer");

   // frames cannot match on two windows one byte apart
   a_no_adjacent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_frame_ok) |=> !(rsp_valid && rsp_frame_ok))
      else $error("frame reported on consecutive results");

endmodule

bind time_frame_check_and_decode tfcd_checker u_tfcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_frame_ok    (rsp_frame_ok),
   .rsp_millis      (rsp_millis),
   .rsp_seconds     (rsp_seconds),
   .rsp_minutes     (rsp_minutes),
   .rsp_hour        (rsp_hour),
   .rsp_summer_time (rsp_summer_time),
   .rsp_day         (rsp_day),
   .rsp_weekday     (rsp_weekday),
   .rsp_month       (rsp_month),
   .rsp_year        (rsp_year)
);
